@@ hw/rtl/ssrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_pkg: servo speed ramp controller shared types
// Input and result words, per-channel state entry, shared ALU request and
// response, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
package ssrc_pkg;

  localparam int POS_W      = 16;
  localparam int SPEED_W    = 16;
  localparam int FRAC_BITS  = 5;
  localparam int ACC_W      = 17;
  localparam int DELTA_W    = ACC_W - FRAC_BITS;
  localparam int DIFF_W     = 18;
  localparam int DEN_SHIFT  = 4;
  localparam int DEN_W      = 16 - DEN_SHIFT;
  localparam int NUM_W      = 25;
  localparam int ALU_W      = 26;
  localparam int CNT_W      = 5;
  localparam int MAX_REPORT = 8;
  localparam int CH_CMP_W   = 7;

  localparam logic [7:0]         PERIOD_RESET = 8'd20;
  localparam logic [SPEED_W-1:0] SPEED_MAX    = 16'hFFFF;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SPEED = 2'd1;
  localparam logic [1:0] KIND_TIME  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         channel;
    logic signed [15:0] target_position;
    logic [7:0]         move_speed;
    logic [15:0]        move_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [15:0] out_position;
    logic               out_moving;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] tgt;
    logic [SPEED_W-1:0]      speed;
    logic [FRAC_BITS-1:0]    frac;
    logic                    active;
  } chan_t;

  localparam int CHAN_W = $bits(chan_t);

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRD,
    S_TLD,
    S_TDIF,
    S_TACC,
    S_TCMP,
    S_TPOS,
    S_TEMIT,
    S_MRD,
    S_MLD,
    S_MDIF,
    S_MABS,
    S_MMUL,
    S_MDIV,
    S_MFIN,
    S_MWR
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/servo_speed_ramp_controller.sv @@
`default_nettype none
// Tick: each channel is read and loaded; an idle one goes to emit, one at its target
// stops after the difference, a ramping one accumulates, compares and steps or clamps,
// plus any wait on the result port. Speed move or jump: read, load, write. Timed move:
// difference, magnitude, 8-step shift-add multiply and 25-step restoring divide on the
// shared ALU, skipped under 16 ms. Other words dropped. One word in flight, in_ready
// only while idle. Reset (synchronous): all channels zero and idle, frame period 20 ms.
// ----------------------------------------------------------------------------
// servo_speed_ramp_controller: per-channel servo speed ramp controller
// Channel state in RAM, sequencer with one shared adder, frame period register.
// ----------------------------------------------------------------------------
module servo_speed_ramp_controller #(
  parameter int CHANNELS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssrc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ssrc_pkg::out_item_t      out_data
);

  localparam int IW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

  logic [7:0]                  frame_period;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [IW-1:0]               ram_raddr;
  logic [ssrc_pkg::CHAN_W-1:0] ram_wdata;
  logic [ssrc_pkg::CHAN_W-1:0] ram_rdata;
  ssrc_pkg::alu_req_t          alu_req;
  ssrc_pkg::alu_rsp_t          alu_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= ssrc_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_period <= cfg_data;
    end
  end

  ssrc_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_period (frame_period),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .alu_req      (alu_req),
    .alu_rsp      (alu_rsp)
  );

  ssrc_ram #(
    .WIDTH(ssrc_pkg::CHAN_W),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssrc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // a tick always leaves the block busy in the cycle after it is taken
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind == ssrc_pkg::KIND_TICK |=> !in_ready)
    else $error("tick accepted but block ready next cycle");

  // a waiting result word holds still until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while waiting");

  // more words of the tick still to come, so input stays blocked
  a_mid_tick_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.out_last |-> !in_ready)
    else $error("input ready in the middle of a tick");

endmodule
`default_nettype wire

@@ hw/rtl/ssrc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/ssrc_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_alu: shared add/subtract unit
// Single wide adder used for differences, accumulation, shift-add multiply
// and restoring divide steps. Carry out is set on a >= b when subtracting.
// ----------------------------------------------------------------------------
module ssrc_alu (
  input  wire ssrc_pkg::alu_req_t req,
  output ssrc_pkg::alu_rsp_t      rsp
);

  logic [ssrc_pkg::ALU_W-1:0] b_eff;
  logic [ssrc_pkg::ALU_W:0]   total;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff} + (ssrc_pkg::ALU_W + 1)'(req.sub);

  assign rsp.sum   = total[ssrc_pkg::ALU_W-1:0];
  assign rsp.carry = total[ssrc_pkg::ALU_W];

endmodule
`default_nettype wire

@@ hw/rtl/ssrc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_ctrl: sequencer and datapath registers
// Walks ticks channel by channel and works move commands through the shared
// ALU: difference, magnitude, shift-add multiply, restoring divide.
// ----------------------------------------------------------------------------
module ssrc_ctrl #(
  parameter int CHANNELS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             frame_period,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire ssrc_pkg::in_item_t     in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ssrc_pkg::out_item_t         out_data,
  output logic                        ram_we,
  output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ram_waddr,
  output logic [ssrc_pkg::CHAN_W-1:0] ram_wdata,
  output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ram_raddr,
  input  wire logic [ssrc_pkg::CHAN_W-1:0] ram_rdata,
  output ssrc_pkg::alu_req_t          alu_req,
  input  wire ssrc_pkg::alu_rsp_t     alu_rsp
);

  localparam int IW   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int NREP = CHANNELS < ssrc_pkg::MAX_REPORT ? CHANNELS : ssrc_pkg::MAX_REPORT;
  localparam int AW   = ssrc_pkg::ALU_W;

  ssrc_pkg::state_t state, state_next;

  logic [IW-1:0]                     idx;
  logic [CHANNELS-1:0]               vld;
  logic                              ent_vld;
  ssrc_pkg::in_item_t                item;
  ssrc_pkg::chan_t                   ent;
  ssrc_pkg::chan_t                   rd_ent;
  ssrc_pkg::chan_t                   mld_ent;
  logic [ssrc_pkg::DIFF_W-1:0]       d;
  logic [ssrc_pkg::DELTA_W-1:0]      delta;
  logic [ssrc_pkg::NUM_W-1:0]        acc;
  logic [ssrc_pkg::DEN_W-1:0]        rem;
  logic [ssrc_pkg::CNT_W-1:0]        cnt;

  logic [ssrc_pkg::DEN_W-1:0]        den;
  logic [ssrc_pkg::DEN_W:0]          trial;
  logic                              sum_zero;
  logic                              clamp;
  logic                              report;
  logic                              emit_go;
  logic                              last_ch;
  logic                              move_ok;

  assign den      = item.move_time_ms[15:ssrc_pkg::DEN_SHIFT];
  assign trial    = {rem, acc[ssrc_pkg::NUM_W-1]};
  assign sum_zero = alu_rsp.sum[ssrc_pkg::DIFF_W-1:0] == '0;
  // d > 0 clamps when d - delta goes negative, d < 0 when d + delta goes positive
  assign clamp    = d[ssrc_pkg::DIFF_W-1] ? (!alu_rsp.sum[AW-1] && !sum_zero)
                                          : alu_rsp.sum[AW-1];
  assign report   = ssrc_pkg::CH_CMP_W'(idx) < ssrc_pkg::CH_CMP_W'(NREP);
  assign emit_go  = !report || !out_valid || out_ready;
  assign last_ch  = idx == IW'(CHANNELS - 1);
  assign move_ok  = (in_data.kind == ssrc_pkg::KIND_SPEED || in_data.kind == ssrc_pkg::KIND_TIME)
                    && (ssrc_pkg::CH_CMP_W'(in_data.channel) < ssrc_pkg::CH_CMP_W'(CHANNELS));

  assign rd_ent = ent_vld ? ssrc_pkg::chan_t'(ram_rdata) : '0;

  always_comb begin
    mld_ent = rd_ent;
    if (item.kind == ssrc_pkg::KIND_SPEED) begin
      if (item.move_speed == '0) begin
        mld_ent.pos    = item.target_position;
        mld_ent.active = 1'b0;
      end else begin
        mld_ent.speed  = ssrc_pkg::SPEED_W'(item.move_speed);
        mld_ent.tgt    = item.target_position;
        mld_ent.active = 1'b1;
      end
    end else if (item.move_time_ms == '0) begin
      mld_ent.pos    = item.target_position;
      mld_ent.active = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ssrc_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == ssrc_pkg::KIND_TICK) state_next = ssrc_pkg::S_TRD;
          else if (move_ok) state_next = ssrc_pkg::S_MRD;
        end
      end
      ssrc_pkg::S_TRD:  state_next = ssrc_pkg::S_TLD;
      ssrc_pkg::S_TLD:  state_next = rd_ent.active ? ssrc_pkg::S_TDIF : ssrc_pkg::S_TEMIT;
      ssrc_pkg::S_TDIF: state_next = sum_zero ? ssrc_pkg::S_TEMIT : ssrc_pkg::S_TACC;
      ssrc_pkg::S_TACC: state_next = ssrc_pkg::S_TCMP;
      ssrc_pkg::S_TCMP: state_next = clamp ? ssrc_pkg::S_TEMIT : ssrc_pkg::S_TPOS;
      ssrc_pkg::S_TPOS: state_next = ssrc_pkg::S_TEMIT;
      ssrc_pkg::S_TEMIT: begin
        if (emit_go) state_next = last_ch ? ssrc_pkg::S_IDLE : ssrc_pkg::S_TRD;
      end
      ssrc_pkg::S_MRD:  state_next = ssrc_pkg::S_MLD;
      ssrc_pkg::S_MLD: begin
        if (item.kind == ssrc_pkg::KIND_TIME && item.move_time_ms != '0)
          state_next = ssrc_pkg::S_MDIF;
        else
          state_next = ssrc_pkg::S_MWR;
      end
      ssrc_pkg::S_MDIF: state_next = ssrc_pkg::S_MABS;
      ssrc_pkg::S_MABS: state_next = ssrc_pkg::S_MMUL;
      ssrc_pkg::S_MMUL: begin
        if (cnt == '0) state_next = (den == '0) ? ssrc_pkg::S_MFIN : ssrc_pkg::S_MDIV;
      end
      ssrc_pkg::S_MDIV: begin
        if (cnt == '0) state_next = ssrc_pkg::S_MFIN;
      end
      ssrc_pkg::S_MFIN: state_next = ssrc_pkg::S_MWR;
      ssrc_pkg::S_MWR:  state_next = ssrc_pkg::S_IDLE;
      default:          state_next = ssrc_pkg::S_IDLE;
    endcase
  end

  // outputs and ALU operand select
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state)
      ssrc_pkg::S_IDLE: in_ready = 1'b1;
      ssrc_pkg::S_TDIF: begin
        alu_req.a   = AW'(ent.tgt);
        alu_req.b   = AW'(ent.pos);
        alu_req.sub = 1'b1;
      end
      // distance from the current position to the new target
      ssrc_pkg::S_MDIF: begin
        alu_req.a   = AW'(item.target_position);
        alu_req.b   = AW'(ent.pos);
        alu_req.sub = 1'b1;
      end
      ssrc_pkg::S_TACC: begin
        alu_req.a = AW'(ent.speed);
        alu_req.b = AW'(ent.frac);
      end
      ssrc_pkg::S_TCMP: begin
        alu_req.a   = {{(AW - ssrc_pkg::DIFF_W){d[ssrc_pkg::DIFF_W-1]}}, d};
        alu_req.b   = AW'(delta);
        alu_req.sub = !d[ssrc_pkg::DIFF_W-1];
      end
      ssrc_pkg::S_TPOS: begin
        alu_req.a   = AW'(ent.tgt);
        alu_req.b   = {{(AW - ssrc_pkg::DIFF_W){d[ssrc_pkg::DIFF_W-1]}}, d};
        alu_req.sub = 1'b1;
      end
      ssrc_pkg::S_TEMIT: ram_we = emit_go;
      ssrc_pkg::S_MABS: begin
        if (d[ssrc_pkg::DIFF_W-1]) begin
          alu_req.b   = {{(AW - ssrc_pkg::DIFF_W){1'b1}}, d};
          alu_req.sub = 1'b1;
        end else begin
          alu_req.a = AW'(d);
        end
      end
      ssrc_pkg::S_MMUL: begin
        alu_req.a = {acc, 1'b0};
        alu_req.b = frame_period[cnt[2:0]] ? AW'(d[ssrc_pkg::POS_W-1:0]) : '0;
      end
      ssrc_pkg::S_MDIV: begin
        alu_req.a   = AW'(trial);
        alu_req.b   = AW'(den);
        alu_req.sub = 1'b1;
      end
      ssrc_pkg::S_MWR: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign ram_waddr = idx;
  assign ram_raddr = idx;
  assign ram_wdata = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssrc_pkg::S_IDLE;
      vld   <= '0;
    end else begin
      state <= state_next;
      if (ram_we) vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ent_vld <= vld[idx];
    case (state)
      ssrc_pkg::S_IDLE: begin
        if (in_valid) begin
          item <= in_data;
          idx  <= (in_data.kind == ssrc_pkg::KIND_TICK) ? '0 : IW'(in_data.channel);
        end
      end
      ssrc_pkg::S_TLD: ent <= rd_ent;
      ssrc_pkg::S_MLD: ent <= mld_ent;
      ssrc_pkg::S_TDIF: begin
        d <= alu_rsp.sum[ssrc_pkg::DIFF_W-1:0];
        if (sum_zero) begin
          ent.active <= 1'b0;
          ent.frac   <= '0;
        end
      end
      ssrc_pkg::S_MDIF: d <= alu_rsp.sum[ssrc_pkg::DIFF_W-1:0];
      ssrc_pkg::S_TACC: begin
        // remainder after taking whole steps is just the fraction bits
        ent.frac <= alu_rsp.sum[ssrc_pkg::FRAC_BITS-1:0];
        delta    <= alu_rsp.sum[ssrc_pkg::ACC_W-1:ssrc_pkg::FRAC_BITS];
      end
      ssrc_pkg::S_TCMP: begin
        if (clamp) ent.pos <= ent.tgt;
        else d <= alu_rsp.sum[ssrc_pkg::DIFF_W-1:0];
      end
      ssrc_pkg::S_TPOS: ent.pos <= alu_rsp.sum[ssrc_pkg::POS_W-1:0];
      ssrc_pkg::S_TEMIT: begin
        if (emit_go && !last_ch) idx <= IW'(idx + 1'b1);
      end
      ssrc_pkg::S_MABS: begin
        d   <= ssrc_pkg::DIFF_W'(alu_rsp.sum[ssrc_pkg::POS_W-1:0]);
        cnt <= ssrc_pkg::CNT_W'(7);
        acc <= '0;
      end
      ssrc_pkg::S_MMUL: begin
        if (cnt == '0) begin
          // doubled product becomes the dividend
          acc <= {alu_rsp.sum[ssrc_pkg::NUM_W-2:0], 1'b0};
          cnt <= ssrc_pkg::CNT_W'(ssrc_pkg::NUM_W - 1);
          rem <= '0;
        end else begin
          acc <= alu_rsp.sum[ssrc_pkg::NUM_W-1:0];
          cnt <= cnt - 1'b1;
        end
      end
      ssrc_pkg::S_MDIV: begin
        rem <= alu_rsp.carry ? alu_rsp.sum[ssrc_pkg::DEN_W-1:0] : trial[ssrc_pkg::DEN_W-1:0];
        acc <= {acc[ssrc_pkg::NUM_W-2:0], alu_rsp.carry};
        cnt <= cnt - 1'b1;
      end
      ssrc_pkg::S_MFIN: begin
        if (den == '0 || acc[ssrc_pkg::NUM_W-1:ssrc_pkg::SPEED_W] != '0)
          ent.speed <= ssrc_pkg::SPEED_MAX;
        else
          ent.speed <= acc[ssrc_pkg::SPEED_W-1:0];
        ent.tgt    <= item.target_position;
        ent.active <= 1'b1;
      end
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ssrc_pkg::S_TEMIT && emit_go && report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ssrc_pkg::S_TEMIT && emit_go && report) begin
      out_data.out_channel  <= 3'(idx);
      out_data.out_position <= ent.pos;
      out_data.out_moving   <= ent.active;
      out_data.out_last     <= ssrc_pkg::CH_CMP_W'(idx) == ssrc_pkg::CH_CMP_W'(NREP - 1);
    end
  end

endmodule
`default_nettype wire
